### rtl/bhtar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhtar_pkg
// Types and constants shared by the bucketed hash table and its checker.
// ----------------------------------------------------------------------------
package bhtar_pkg;

   // Port widths
   localparam int KEY_W       = 64;
   localparam int REQ_TDATA_W = 128;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [1:0] {
      OP_PROBE      = 2'd0,
      OP_STORE      = 2'd1,
      OP_NEW_SEARCH = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEEP_MARGIN = 2'd0,
      CSR_AGE_WEIGHT  = 2'd1,
      CSR_EXACT_CODE  = 2'd2
   } csr_index_type;

   localparam logic [3:0] KEEP_MARGIN_RST = 4'd3;
   localparam logic [3:0] AGE_WEIGHT_RST  = 4'd4;
   localparam logic [1:0] EXACT_CODE_RST  = 2'd0;

   localparam logic [7:0] DEPTH1_MAX = 8'd255;

   // Stored entry, generation in the top bits
   typedef struct packed {
      logic [5:0]  gen;
      logic [1:0]  bound;
      logic [7:0]  depth1;
      logic [15:0] move;
      logic [15:0] static_score;
      logic [15:0] score;
   } entry_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      entry_type        data;
   } slot_type;

   // Request word payload, key in the lowest bits
   typedef struct packed {
      logic               move_is_null;
      logic [15:0]        best_move;
      logic [1:0]         bound_type;
      logic signed [15:0] static_score;
      logic signed [15:0] score;
      logic signed [8:0]  search_depth;
      logic [KEY_W-1:0]   key;
   } req_data_type;

   // Response word payload, hit_score in the lowest bits
   typedef struct packed {
      logic [15:0] hit_move;
      logic [1:0]  hit_bound_type;
      logic [8:0]  hit_depth;
      logic [15:0] hit_static_score;
      logic [15:0] hit_score;
   } rsp_data_type;

endpackage

### rtl/bucketed_hash_table_with_aging_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_hash_table_with_aging_replace
// Set-associative position table with depth and age based replacement.
// ----------------------------------------------------------------------------
// A word is handled thus: the accept edge reads the whole bucket (WAYS slots)
// from one synchronous bucket RAM, and the next edge at which the response
// register is free compares keys, picks the victim, writes the bucket back and
// loads the response register; a stalled previous response holds the word in
// that second step. A new word is taken once that write-back is done, even
// while the response still waits on rsp_tready. After reset and after every
// clear word the table RAM is swept one bucket per cycle over all 2^INDEX_BITS
// buckets (1024 by default) with req_tready low; csr writes are taken during it.
module bucketed_hash_table_with_aging_replace #(
   parameter int INDEX_BITS = 10,
   parameter int WAYS       = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // key[63:0], search_depth[72:64], score[88:73], static_score[104:89],
   // bound_type[106:105], best_move[122:107], move_is_null[123], zero fill
   input  logic [bhtar_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // opcode[1:0]
   input  logic [bhtar_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit_score[15:0], hit_static_score[31:16], hit_depth[40:32],
   // hit_bound_type[42:41], hit_move[58:43], zero fill
   output logic [bhtar_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // hit[0]
   output logic [bhtar_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                               csr_we,
   input  logic [bhtar_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bhtar_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bhtar_pkg::*;

   localparam int BUCKETS  = 1 << INDEX_BITS;
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   slot_type [WAYS-1:0] mem [BUCKETS];
   slot_type [WAYS-1:0] rd_row_ff;
   slot_type [WAYS-1:0] new_row;
   slot_type [WAYS-1:0] wr_row;
   logic [INDEX_BITS-1:0] wr_addr;
   logic wr_en;

   state_type state_ff, state_in;
   logic [INDEX_BITS-1:0] clr_idx_ff, clr_idx_in;
   op_type op_ff, op_in;
   req_data_type req_ff, req_in;
   logic [5:0] gen_ff, gen_in;
   logic [3:0] keep_margin_ff, keep_margin_in;
   logic [3:0] age_weight_ff, age_weight_in;
   logic [1:0] exact_code_ff, exact_code_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic accept, out_free, fire;
   logic probe_hit;
   entry_type probe_entry;
   logic [WAY_BITS-1:0] victim;
   logic same, skip;
   logic signed [10:0] depth_ext, thresh, dp1;
   logic [7:0] d1;
   entry_type new_entry;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = (state_ff == ST_EXEC) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = RSP_TUSER_W'(rsp_hit_ff);
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   // Bucket RAM: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (accept) begin
         rd_row_ff <= mem[req_tdata[INDEX_BITS-1:0]];
      end
   end

   // Probe: first valid slot with the full key
   always_comb begin
      probe_hit   = 1'b0;
      probe_entry = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!probe_hit && rd_row_ff[i].valid && rd_row_ff[i].key == req_ff.key) begin
            probe_hit   = 1'b1;
            probe_entry = rd_row_ff[i].data;
         end
      end
   end

   assign depth_ext = $signed({{2{req_ff.search_depth[8]}}, req_ff.search_depth});
   assign thresh    = depth_ext + $signed({7'b0, keep_margin_ff});

   // Store: victim search over the bucket
   always_comb begin
      logic signed [10:0] sd_v;
      logic signed [10:0] val_v;
      logic signed [10:0] worst;
      logic [5:0] age_v;
      logic [9:0] pen_v;
      logic done, have_worst;
      victim     = '0;
      same       = 1'b0;
      skip       = 1'b0;
      done       = 1'b0;
      have_worst = 1'b0;
      worst      = '0;
      for (int i = 0; i < WAYS; i++) begin
         sd_v  = $signed({3'b0, rd_row_ff[i].data.depth1}) - 11'sd1;
         age_v = gen_ff - rd_row_ff[i].data.gen;
         pen_v = {6'b0, age_weight_ff} * {4'b0, age_v};
         val_v = sd_v - $signed({1'b0, pen_v});
         if (!done) begin
            if (!rd_row_ff[i].valid) begin
               victim = WAY_BITS'(i);
               done   = 1'b1;
            end else if (rd_row_ff[i].key == req_ff.key) begin
               // deep exact entry resists a non-exact overwrite
               if (sd_v > thresh && rd_row_ff[i].data.bound == exact_code_ff &&
                   req_ff.bound_type != exact_code_ff) begin
                  skip = 1'b1;
               end
               victim = WAY_BITS'(i);
               same   = 1'b1;
               done   = 1'b1;
            end else if (!have_worst || val_v < worst) begin
               worst      = val_v;
               victim     = WAY_BITS'(i);
               have_worst = 1'b1;
            end
         end
      end
   end

   assign dp1 = depth_ext + 11'sd1;

   always_comb begin
      priority if (dp1 < 11'sd0) begin
         d1 = 8'd0;
      end else if (dp1 > $signed({3'b0, DEPTH1_MAX})) begin
         d1 = DEPTH1_MAX;
      end else begin
         d1 = dp1[7:0];
      end
   end

   always_comb begin
      new_entry.gen          = gen_ff;
      new_entry.bound        = req_ff.bound_type;
      new_entry.depth1       = d1;
      new_entry.move         = (req_ff.move_is_null && same) ?
                               rd_row_ff[victim].data.move : req_ff.best_move;
      new_entry.static_score = req_ff.static_score;
      new_entry.score        = req_ff.score;
      new_row                = rd_row_ff;
      new_row[victim].valid  = 1'b1;
      new_row[victim].key    = req_ff.key;
      new_row[victim].data   = new_entry;
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_idx_ff;
         wr_row  = '0;
      end else begin
         wr_en   = fire && (op_ff == OP_STORE) && !skip;
         wr_addr = req_ff.key[INDEX_BITS-1:0];
         wr_row  = new_row;
      end
   end

   // Next state
   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      gen_in         = gen_ff;
      op_in          = op_ff;
      req_in         = req_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_data_in    = rsp_data_ff;
      keep_margin_in = keep_margin_ff;
      age_weight_in  = age_weight_ff;
      exact_code_in  = exact_code_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_KEEP_MARGIN: keep_margin_in = csr_data[3:0];
            CSR_AGE_WEIGHT:  age_weight_in  = csr_data[3:0];
            CSR_EXACT_CODE:  exact_code_in  = csr_data[1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_tuser);
               req_in   = req_data_type'(req_tdata[$bits(req_data_type)-1:0]);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = (op_ff == OP_PROBE) && probe_hit;
               if ((op_ff == OP_PROBE) && probe_hit) begin
                  rsp_data_in.hit_score        = probe_entry.score;
                  rsp_data_in.hit_static_score = probe_entry.static_score;
                  rsp_data_in.hit_depth        = {1'b0, probe_entry.depth1} - 9'd1;
                  rsp_data_in.hit_bound_type   = probe_entry.bound;
                  rsp_data_in.hit_move         = probe_entry.move;
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
               unique case (op_ff)
                  OP_NEW_SEARCH: gen_in = gen_ff + 6'd1;
                  OP_CLEAR: begin
                     gen_in     = '0;
                     clr_idx_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      req_ff      <= req_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         gen_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         keep_margin_ff <= KEEP_MARGIN_RST;
         age_weight_ff  <= AGE_WEIGHT_RST;
         exact_code_ff  <= EXACT_CODE_RST;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         gen_ff         <= gen_in;
         rsp_valid_ff   <= rsp_valid_in;
         keep_margin_ff <= keep_margin_in;
         age_weight_ff  <= age_weight_in;
         exact_code_ff  <= exact_code_in;
      end
   end

endmodule

### rtl/bhtar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhtar_checker
// Port-level checks for the bucketed hash table, bound to the top level.
// ----------------------------------------------------------------------------
module bhtar_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bhtar_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [bhtar_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import bhtar_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // table sweep follows reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during table sweep");

   // one word at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous word in flight");

   // a miss carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss response with nonzero payload");

endmodule

bind bucketed_hash_table_with_aging_replace bhtar_checker u_bhtar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
